/* rtl/binary_trie_max_xor_engine_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the binary trie max-xor engine.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
// ---------------------------------------------------------------------------
`ifndef BINARY_TRIE_MAX_XOR_ENGINE_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTMX_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTMX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/btmx_pkg.sv */
// ---------------------------------------------------------------------------
// btmx_pkg
// Shared constants, operation codes and the command and status bundles that
// join the controller and the datapath of the max-xor trie engine.
// ---------------------------------------------------------------------------
package btmx_pkg;

   // Fixed width of the value and result ports.
   localparam int VALUE_W = 32;

   // Default trie depth and node store size.
   localparam int DEF_VALUE_BITS = 32;
   localparam int DEF_MAX_NODES  = 32768;

   // Operation codes carried in the mode field.
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture a new item and reset the walk
      logic clear;   // empty the trie
      logic step;    // walk one trie level
      logic alloc;   // write one newly allocated node
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_insert;   // the item in work is an insert
      logic missing;     // no branch to follow at the current level
      logic last_level;  // the walk is at the bottom bit
      logic fits;        // the nodes still needed fit in the store
      logic root_empty;  // the trie holds no value
   } stat_type;

endpackage

/* rtl/btmx_ctrl.sv */
// ---------------------------------------------------------------------------
// btmx_ctrl
// Controller state machine: accepts an item, sequences the trie walk and the
// node allocation in the datapath, and strobes the result for one cycle.
// ---------------------------------------------------------------------------
module btmx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_mode,
   input  btmx_pkg::stat_type stat,
   output btmx_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);
   import btmx_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_ALLOC = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_mode)
                  MODE_INSERT: state_in = ST_WALK;
                  MODE_QUERY:  state_in = stat.root_empty ? ST_RESP : ST_WALK;
                  MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_RESP;
                  end
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.missing) begin
               // An insert that fits goes on to allocate; a full store rejects.
               state_in = (stat.is_insert && stat.fits) ? ST_ALLOC : ST_RESP;
            end else if (stat.last_level) begin
               state_in = ST_RESP;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (stat.last_level) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

/* rtl/btmx_datapath.sv */
// ---------------------------------------------------------------------------
// btmx_datapath
// Node store, root links, node counter and walk registers. One trie level is
// processed per cycle from the registered read of the node memory.
// ---------------------------------------------------------------------------
module btmx_datapath #(
   parameter int VALUE_BITS = btmx_pkg::DEF_VALUE_BITS,
   parameter int MAX_NODES  = btmx_pkg::DEF_MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  btmx_pkg::cmd_type     cmd,
   input  logic [1:0]            req_mode,
   input  logic [VALUE_BITS-1:0] req_value,
   output btmx_pkg::stat_type    stat,
   output logic                  rsp_status,
   output logic                  rsp_found,
   output logic [VALUE_BITS-1:0] rsp_best
);
   import btmx_pkg::*;

   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int USED_BITS  = $clog2(MAX_NODES + 1);
   localparam int LEVEL_BITS = $clog2(VALUE_BITS);
   localparam int SUM_BITS   = USED_BITS + LEVEL_BITS + 1;

   // Link pair of one node; a zero link means no child.
   typedef logic [1:0][NODE_BITS-1:0] links_type;

   links_type node_mem [MAX_NODES];
   links_type rd_links_ff;
   links_type root_ff, root_in;
   links_type cur_links;
   links_type wr_data;
   links_type leaf_links;

   logic [NODE_BITS-1:0]  wr_addr;
   logic                  wr_en;
   logic [NODE_BITS-1:0]  same_node, opp_node, next_node;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in, lower_level;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [SUM_BITS-1:0]   need_sum;
   logic                  at_root_ff, at_root_in;
   logic                  insert_ff, insert_in;
   logic                  status_ff, status_in;
   logic                  found_ff, found_in;
   logic                  bit_now, child_bit, take_opp, missing, fits;

   // Branch selection at the current level.
   assign cur_links = at_root_ff ? root_ff : rd_links_ff;
   assign bit_now   = value_ff[level_ff];
   assign same_node = cur_links[bit_now];
   assign opp_node  = cur_links[~bit_now];
   assign take_opp  = !insert_ff && (opp_node != '0);
   assign next_node = take_opp ? opp_node : same_node;
   assign missing   = (next_node == '0);

   // Room check: the nodes from this level down must fit in the store.
   assign need_sum = SUM_BITS'(used_ff) + SUM_BITS'(level_ff) + SUM_BITS'(1);
   assign fits     = (need_sum <= SUM_BITS'(MAX_NODES));

   // A new node links to the node allocated right after it, except at the leaf.
   assign lower_level = level_ff - LEVEL_BITS'(1);
   assign child_bit   = value_ff[lower_level];
   always_comb begin
      leaf_links = '0;
      if (level_ff != '0) begin
         leaf_links[child_bit] = NODE_BITS'(used_ff + USED_BITS'(1));
      end
   end

   // Next-state logic of the walk and the store.
   always_comb begin
      value_in   = value_ff;
      best_in    = best_ff;
      level_in   = level_ff;
      node_in    = node_ff;
      at_root_in = at_root_ff;
      insert_in  = insert_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      root_in    = root_ff;
      used_in    = used_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = cur_links;

      if (cmd.load) begin
         value_in   = req_value;
         best_in    = '0;
         level_in   = LEVEL_BITS'(VALUE_BITS - 1);
         node_in    = '0;
         at_root_in = 1'b1;
         insert_in  = (req_mode == MODE_INSERT);
         status_in  = 1'b0;
         found_in   = (req_mode == MODE_QUERY) && (root_ff != '0);
      end

      if (cmd.clear) begin
         root_in = '0;
         used_in = USED_BITS'(1);
      end

      if (cmd.step) begin
         if (!missing) begin
            node_in    = next_node;
            at_root_in = 1'b0;
            level_in   = lower_level;
            if (take_opp) begin
               best_in[level_ff] = 1'b1;
            end
         end else if (insert_ff) begin
            if (fits) begin
               // Hook the first new node under the node where the path ends.
               if (at_root_ff) begin
                  root_in[bit_now] = NODE_BITS'(used_ff);
               end else begin
                  wr_en            = 1'b1;
                  wr_addr          = node_ff;
                  wr_data[bit_now] = NODE_BITS'(used_ff);
               end
            end else begin
               status_in = 1'b1;
            end
         end
      end

      if (cmd.alloc) begin
         wr_en    = 1'b1;
         wr_addr  = NODE_BITS'(used_ff);
         wr_data  = leaf_links;
         used_in  = used_ff + USED_BITS'(1);
         level_in = lower_level;
      end
   end

   // Node memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_links_ff <= node_mem[next_node];
   end

   // Trie control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
         used_ff <= USED_BITS'(1);
      end else begin
         root_ff <= root_in;
         used_ff <= used_in;
      end
   end

   // Walk and result registers.
   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      best_ff    <= best_in;
      level_ff   <= level_in;
      node_ff    <= node_in;
      at_root_ff <= at_root_in;
      insert_ff  <= insert_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
   end

   assign stat.is_insert  = insert_ff;
   assign stat.missing    = missing;
   assign stat.last_level = (level_ff == '0);
   assign stat.fits       = fits;
   assign stat.root_empty = (root_ff == '0);

   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_best   = best_ff;

endmodule

/* rtl/binary_trie_max_xor_engine.sv */
// ---------------------------------------------------------------------------
// binary_trie_max_xor_engine
// Binary trie over VALUE_BITS-bit values with insert, max-xor query and clear.
// Input: an item (req_mode, req_value) is taken when start is high and busy
// is low. Result: rsp_status, rsp_found and rsp_best_xor are valid for the one
// cycle that rsp_valid is high; the receiver cannot stall, so every result is
// taken in that cycle. One item is in work at a time.
// Sequence: a query walks one trie level per cycle from the registered read of
// the node memory, then strobes; an empty query, clear and unused mode go from
// the accept state straight to the response state; an insert walks its path
// and, when the value is new, writes the missing nodes one per cycle below
// where the path ends, then strobes; when the store is full the insert is
// rejected where its path ends.
// The next item can be accepted in the cycle after the strobe.
// Reset empties the trie at once (root links and node count are registers);
// no clearing pass runs, nodes are written as they are allocated.
// ---------------------------------------------------------------------------
`include "binary_trie_max_xor_engine_assert.svh"

module binary_trie_max_xor_engine #(
   parameter int VALUE_BITS = btmx_pkg::DEF_VALUE_BITS,
   parameter int MAX_NODES  = btmx_pkg::DEF_MAX_NODES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_mode,
   input  logic [btmx_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   output logic                         rsp_status,
   output logic                         rsp_found,
   output logic [btmx_pkg::VALUE_W-1:0] rsp_best_xor
);
   import btmx_pkg::*;

   cmd_type               cmd;
   stat_type              stat;
   logic [VALUE_BITS-1:0] req_value_trim;
   logic [VALUE_BITS-1:0] best;

   // Only the low VALUE_BITS bits of the value take part.
   assign req_value_trim = VALUE_BITS'(req_value);
   assign rsp_best_xor   = VALUE_W'(best);

   btmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   btmx_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_NODES  (MAX_NODES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_mode   (req_mode),
      .req_value  (req_value_trim),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_best   (best)
   );

   // Checks on the sequencing.
   `BTMX_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "strobe too long")
   `BTMX_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `BTMX_ASSERT_IMPLY(a_alloc_insert, clock, reset, cmd.alloc, stat.is_insert, "stray alloc")
   `BTMX_ASSERT_IMPLY(a_found_status, clock, reset, rsp_valid && rsp_found, !rsp_status, "both flags")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the binary trie max-xor engine
// Drives insert, query, clear and unused-mode items through the start/busy
// handshake in random bursts, keeps a shadow trie that computes each answer,
// and compares every strobed answer with the oldest answer still owed.
// ----------------------------------------------------------------------------
module tb_top;
   import btmx_pkg::*;

   localparam int VALUE_BITS = DEF_VALUE_BITS;
   localparam int MAX_NODES = DEF_MAX_NODES;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = VALUE_BITS + 8;
   localparam int RANDOM_ITEMS = 260;
   localparam int FILL_INSERTS = 280;

   typedef struct packed {
      logic [1:0] mode;
      logic [VALUE_W-1:0] value;
   } trie_command_type;

   typedef struct packed {
      logic status;
      logic found;
      logic [VALUE_W-1:0] best_xor;
   } trie_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = MODE_INSERT;
   logic [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_status;
   logic rsp_found;
   logic [VALUE_W-1:0] rsp_best_xor;

   // Commands waiting to be driven, and answers owed by the engine.
   trie_command_type queued_commands[$];
   trie_answer_type pending_answers[$];
   logic [VALUE_W-1:0] stored_values[$];

   // Shadow copy of the trie: two child links per node and the node count.
   int unsigned shadow_links[MAX_NODES][2];
   int unsigned shadow_node_count = 1;

   int commands_issued = 0;
   int commands_taken = 0;
   int bad_answers = 0;
   int burst_left = 8;
   int gap_left = 0;

   binary_trie_max_xor_engine #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_NODES(MAX_NODES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_best_xor(rsp_best_xor)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Adds a value to the shadow trie; returns 1 when the missing nodes do not
   // fit in the store, in which case nothing is written.
   function automatic logic shadow_insert(logic [VALUE_W-1:0] v);
      int unsigned node;
      int unsigned next;
      int unsigned need;
      int i;
      node = 0;
      need = 0;
      for (i = VALUE_BITS - 1; i >= 0; i--) begin
         next = shadow_links[node][v[i]];
         if (next == 0) begin
            need = i + 1;
            break;
         end
         node = next;
      end
      if (need > MAX_NODES - shadow_node_count) begin
         return 1'b1;
      end
      node = 0;
      for (i = VALUE_BITS - 1; i >= 0; i--) begin
         next = shadow_links[node][v[i]];
         if (next == 0) begin
            next = shadow_node_count;
            shadow_node_count++;
            shadow_links[next][0] = 0;
            shadow_links[next][1] = 0;
            shadow_links[node][v[i]] = next;
         end
         node = next;
      end
      return 1'b0;
   endfunction

   // Walks the shadow trie preferring the opposite bit at every level.
   function automatic logic [VALUE_W-1:0] shadow_best_xor(logic [VALUE_W-1:0] v);
      int unsigned node;
      logic [VALUE_W-1:0] best;
      int i;
      node = 0;
      best = '0;
      for (i = VALUE_BITS - 1; i >= 0; i--) begin
         if (shadow_links[node][!v[i]] != 0) begin
            best[i] = 1'b1;
            node = shadow_links[node][!v[i]];
         end else if (shadow_links[node][v[i]] != 0) begin
            node = shadow_links[node][v[i]];
         end else begin
            break;
         end
      end
      return best;
   endfunction

   // Applies one accepted item to the shadow trie and returns its answer.
   function automatic trie_answer_type trie_answer(logic [1:0] mode,
                                                   logic [VALUE_W-1:0] v);
      trie_answer_type ans;
      ans = '0;
      case (mode)
         MODE_INSERT: begin
            ans.status = shadow_insert(v);
         end
         MODE_QUERY: begin
            if (shadow_links[0][0] != 0 || shadow_links[0][1] != 0) begin
               ans.found = 1'b1;
               ans.best_xor = shadow_best_xor(v);
            end
         end
         MODE_CLEAR: begin
            shadow_links[0][0] = 0;
            shadow_links[0][1] = 0;
            shadow_node_count = 1;
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic add_command(logic [1:0] mode, logic [VALUE_W-1:0] v);
      queued_commands.insert(queued_commands.size(), {mode, v});
      if (mode == MODE_CLEAR) begin
         stored_values.delete();
      end else if (mode == MODE_INSERT) begin
         stored_values.insert(stored_values.size(), v);
      end
   endtask

   // Random value with a mix of shapes: dense, small, near all ones, only high
   // bits set, or one bit away from a value already stored.
   function automatic logic [VALUE_W-1:0] varied_value();
      logic [VALUE_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 255);
         1: v = ~$urandom_range(0, 255);
         2: v = {v[31:24], 24'h0};
         3: begin
            if (stored_values.size() != 0) begin
               v = stored_values[$urandom_range(0, stored_values.size() - 1)]
                   ^ (32'h1 << $urandom_range(0, 31));
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic report_fault(string what);
      bad_answers++;
      if (bad_answers <= 10) begin
         $display("%s", what);
      end
   endtask

   // Sender: one item per handshake, in bursts with random gaps between them.
   always @(negedge clock) begin
      trie_command_type cmd;
      if (reset) begin
         start <= 1'b0;
      end else if (start && commands_taken != commands_issued) begin
         // The current item has not been taken yet; hold it.
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
         start <= 1'b0;
      end else if (queued_commands.size() != 0) begin
         cmd = queued_commands.pop_front();
         start <= 1'b1;
         req_mode <= cmd.mode;
         req_value <= cmd.value;
         commands_issued++;
         burst_left = burst_left - 1;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Answer checking and prediction of accepted items.
   always @(posedge clock) begin
      trie_answer_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               report_fault($sformatf("unexpected answer: status %0b found %0b best_xor %08h",
                                      rsp_status, rsp_found, rsp_best_xor));
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status || rsp_found !== want.found ||
                   rsp_best_xor !== want.best_xor) begin
                  report_fault($sformatf(
                     "wrong answer: status %0b (want %0b) found %0b (want %0b) %s",
                     rsp_status, want.status, rsp_found, want.found,
                     $sformatf("best_xor %08h (want %08h)", rsp_best_xor, want.best_xor)));
               end
            end
         end
         if (start && !busy) begin
            pending_answers.insert(pending_answers.size(), trie_answer(req_mode, req_value));
            commands_taken++;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int k;
      int j;
      int b;
      int phase_len;
      int pick;
      int random_count;
      logic [10:0] top_bits;
      logic [VALUE_W-1:0] v;

      // Directed: empty queries, unused mode, duplicates and the value extremes.
      add_command(MODE_QUERY, 32'h0000_0000);
      add_command(MODE_QUERY, 32'hffff_ffff);
      add_command(MODE_UNUSED, 32'hdead_beef);
      add_command(MODE_INSERT, 32'h0000_0000);
      add_command(MODE_INSERT, 32'h0000_0000);
      add_command(MODE_QUERY, 32'h0000_0000);
      add_command(MODE_QUERY, 32'hffff_ffff);
      add_command(MODE_INSERT, 32'hffff_ffff);
      add_command(MODE_QUERY, 32'h8000_0000);
      add_command(MODE_INSERT, 32'h8000_0000);
      add_command(MODE_INSERT, 32'h0000_0001);
      add_command(MODE_INSERT, 32'h7fff_ffff);
      add_command(MODE_QUERY, 32'h5555_5555);
      add_command(MODE_QUERY, 32'haaaa_aaaa);
      add_command(MODE_QUERY, 32'h0000_0001);
      add_command(MODE_UNUSED, 32'h0000_0000);
      add_command(MODE_CLEAR, 32'hffff_ffff);
      add_command(MODE_QUERY, 32'h0000_0000);
      add_command(MODE_INSERT, 32'h1234_5678);
      add_command(MODE_QUERY, 32'hedcb_a987);
      add_command(MODE_CLEAR, 32'h0000_0000);
      add_command(MODE_CLEAR, 32'h0000_0000);

      // Grow a wide trie: the top bits count in bit-reversed order so that
      // paths split as high as possible and each insert takes many nodes.
      for (k = 0; k < FILL_INSERTS; k++) begin
         for (b = 0; b < 11; b++) begin
            top_bits[10 - b] = k[b];
         end
         v = $urandom;
         add_command(MODE_INSERT, {top_bits, v[20:0]});
         if (k % 16 == 15) begin
            add_command(MODE_QUERY, $urandom);
         end
      end

      // Inserts one or a few nodes away from stored values, duplicates that
      // need no node, random inserts, and queries.
      for (k = 0; k < 60; k++) begin
         v = stored_values[$urandom_range(0, stored_values.size() - 1)];
         case ($urandom_range(0, 3))
            0: add_command(MODE_INSERT, v ^ (32'h1 << $urandom_range(0, 5)));
            1: add_command(MODE_INSERT, v);
            2: add_command(MODE_INSERT, $urandom);
            default: add_command(MODE_QUERY, varied_value());
         endcase
      end

      // Random phases of inserts, queries and unused-mode items on a trie that is often cleared.
      add_command(MODE_CLEAR, $urandom);
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         phase_len = $urandom_range(8, 60);
         if ($urandom_range(0, 1) == 1) begin
            add_command(MODE_CLEAR, $urandom);
         end
         for (j = 0; j < phase_len; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               add_command(MODE_INSERT, varied_value());
            end else if (pick < 52 && stored_values.size() != 0) begin
               add_command(MODE_INSERT,
                           stored_values[$urandom_range(0, stored_values.size() - 1)]);
            end else if (pick < 92) begin
               add_command(MODE_QUERY, varied_value());
            end else if (pick < 96) begin
               add_command(MODE_UNUSED, $urandom);
            end else begin
               add_command(MODE_CLEAR, $urandom);
            end
         end
         random_count += phase_len;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken and answered, then let the tail pass.
      while (queued_commands.size() != 0 || start || pending_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (bad_answers == 0 && pending_answers.size() == 0) begin
         $display("binary_trie_max_xor_engine: match");
      end else begin
         $display("binary_trie_max_xor_engine: mismatch");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("binary_trie_max_xor_engine: mismatch");
      $finish;
   end

endmodule
